FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

FILE: sv/sld_pkg.sv
// Package for the sync/length/CRC-16 deframer.
// Holds the result and configuration types, code constants and the CRC-16 byte update.
package sld_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SYNC        = 2'd0;
    localparam kind_t KIND_PAYLOAD     = 2'd1;
    localparam kind_t KIND_HDR_CRC_ERR = 2'd2;
    localparam kind_t KIND_LEN_ERR     = 2'd3;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SYNC_FIRST  = 2'd0;
    localparam cfg_idx_t CFG_SYNC_SECOND = 2'd1;
    localparam cfg_idx_t CFG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'hFFFF;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic        data_crc_ok;
        logic [15:0] frame_length;
    } result_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_length;
        logic [15:0] sync_crc;
    } cfg_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    localparam logic [15:0] SYNC_CRC_RST =
        crc16_byte(crc16_byte(16'h0000, SYNC_FIRST_RST), SYNC_SECOND_RST);

endpackage

FILE: sv/sld_cfg_regs.sv
// Configuration registers of the deframer.
// Depends on sld_pkg; also keeps the CRC of the two sync bytes up to date.
module sld_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  sld_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data,
    output sld_pkg::cfg_t     cfg
);
    import sld_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:
                begin
                    cfg_next.sync_first = cfg_data[7:0];
                    cfg_next.sync_crc   = crc16_byte(crc16_byte(16'h0000, cfg_data[7:0]),
                                                     cfg_reg.sync_second);
                end
                CFG_SYNC_SECOND:
                begin
                    cfg_next.sync_second = cfg_data[7:0];
                    cfg_next.sync_crc    = crc16_byte(crc16_byte(16'h0000, cfg_reg.sync_first),
                                                      cfg_data[7:0]);
                end
                CFG_MAX_LENGTH:
                begin
                    cfg_next.max_length = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.max_length  <= MAX_LENGTH_RST;
            cfg_reg.sync_crc    <= SYNC_CRC_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/sld_in_reg.sv
// Input register stage of the deframer: holds one received byte until it is processed.
// No package dependencies.
module sld_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

FILE: sv/sld_frame_core.sv
// Frame parser of the deframer: phase state, header fields, running CRC and byte count.
// Depends on sld_pkg for the CRC update, the result type and the result codes.
module sld_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  sld_pkg::cfg_t    cfg,
    output logic             res_valid,
    output sld_pkg::result_t res
);
    import sld_pkg::*;

    localparam logic [3:0] PH_HUNT1 = 4'd0;
    localparam logic [3:0] PH_HUNT2 = 4'd1;
    localparam logic [3:0] PH_LENH  = 4'd2;
    localparam logic [3:0] PH_LENL  = 4'd3;
    localparam logic [3:0] PH_DCRCH = 4'd4;
    localparam logic [3:0] PH_DCRCL = 4'd5;
    localparam logic [3:0] PH_HCRCH = 4'd6;
    localparam logic [3:0] PH_HCRCL = 4'd7;
    localparam logic [3:0] PH_DATA  = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] exp_crc_reg, exp_crc_next;
    logic [7:0]  hcrc_hi_reg, hcrc_hi_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_step;
    logic [15:0] count_inc;

    assign crc_step  = crc16_byte(crc_reg, rx_byte);
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        exp_crc_next = exp_crc_reg;
        hcrc_hi_next = hcrc_hi_reg;
        crc_next     = crc_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (step)
        begin
            case (phase_reg)
                PH_HUNT2:
                begin
                    if (rx_byte == cfg.sync_second)
                    begin
                        crc_next   = cfg.sync_crc;
                        phase_next = PH_LENH;
                        res_valid  = 1'b1;
                        res.kind   = KIND_SYNC;
                    end
                    else if (rx_byte != cfg.sync_first)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LENH:
                begin
                    length_next = {rx_byte, 8'h00};
                    crc_next    = crc_step;
                    phase_next  = PH_LENL;
                end
                PH_LENL:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    crc_next    = crc_step;
                    phase_next  = PH_DCRCH;
                end
                PH_DCRCH:
                begin
                    exp_crc_next = {rx_byte, 8'h00};
                    crc_next     = crc_step;
                    phase_next   = PH_DCRCL;
                end
                PH_DCRCL:
                begin
                    exp_crc_next = {exp_crc_reg[15:8], rx_byte};
                    crc_next     = crc_step;
                    phase_next   = PH_HCRCH;
                end
                PH_HCRCH:
                begin
                    hcrc_hi_next = rx_byte;
                    phase_next   = PH_HCRCL;
                end
                PH_HCRCL:
                begin
                    if ({hcrc_hi_reg, rx_byte} != crc_reg)
                    begin
                        phase_next       = PH_HUNT1;
                        res_valid        = 1'b1;
                        res.kind         = KIND_HDR_CRC_ERR;
                        res.frame_length = length_reg;
                    end
                    else if (length_reg == 16'd0 || length_reg > cfg.max_length)
                    begin
                        phase_next       = PH_HUNT1;
                        res_valid        = 1'b1;
                        res.kind         = KIND_LEN_ERR;
                        res.frame_length = length_reg;
                    end
                    else
                    begin
                        crc_next   = 16'd0;
                        count_next = 16'd0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    crc_next         = crc_step;
                    count_next       = count_inc;
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                    res.frame_length = length_reg;
                    if (count_inc >= length_reg)
                    begin
                        phase_next      = PH_HUNT1;
                        res.last_byte   = 1'b1;
                        res.data_crc_ok = (crc_step == exp_crc_reg);
                    end
                end
                default:
                begin
                    // Hunting the first sync byte; unused phase codes behave the same.
                    phase_next = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            length_reg  <= 16'd0;
            exp_crc_reg <= 16'd0;
            hcrc_hi_reg <= 8'd0;
            crc_reg     <= 16'd0;
            count_reg   <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            exp_crc_reg <= exp_crc_next;
            hcrc_hi_reg <= hcrc_hi_next;
            crc_reg     <= crc_next;
            count_reg   <= count_next;
        end
    end

endmodule

FILE: sv/sld_out_reg.sv
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on sld_pkg for the result type.
module sld_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  sld_pkg::result_t res,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output sld_pkg::result_t res_out
);
    import sld_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: sv/sync_length_crc16_deframer.sv
// Sync/length/CRC-16 deframer, top level.
// Depends on sld_pkg, sld_cfg_regs, sld_in_reg, sld_frame_core and sld_out_reg.
//
// Received bytes enter on the input channel (in_valid, in_ready, rx_byte), one per transfer.
// The block hunts for the two sync bytes, checks the header CRC and the length, and then
// streams the payload bytes out. Results leave on the output channel (out_valid, out_ready)
// with the fields kind, payload_byte, last_byte, data_crc_ok and frame_length. Bytes of the
// header give no result; the second sync byte gives a preamble result, a bad header gives a
// header CRC or length error result, and each payload byte gives one result.
// An accepted byte waits in the input register until the result register has space, and is
// then processed into it; any result that the byte gives is shown there.
// One byte can be accepted in every cycle unless stalled; the parse logic is combinational.
// When the receiver stalls, the result is held, one more byte waits in the input register,
// and then in_ready drops until the result is taken.
// Configuration writes through cfg_write, cfg_index and cfg_data are registered;
// an unused index is ignored. Reset returns the parser to the hunt, clears the valid flags
// of both registers and restores the configuration defaults.
module sync_length_crc16_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output sld_pkg::kind_t    kind,
    output logic [7:0]        payload_byte,
    output logic              last_byte,
    output logic              data_crc_ok,
    output logic [15:0]       frame_length,
    input  logic              cfg_write,
    input  sld_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data
);
    import sld_pkg::*;

    cfg_t       cfg;
    logic       held_valid;
    logic [7:0] held_byte;
    logic       space;
    logic       take;
    logic       res_valid;
    result_t    res;
    result_t    res_out;

    assign take = held_valid && space;

    sld_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sld_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sld_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .rx_byte   (held_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    sld_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign kind         = res_out.kind;
    assign payload_byte = res_out.payload_byte;
    assign last_byte    = res_out.last_byte;
    assign data_crc_ok  = res_out.data_crc_ok;
    assign frame_length = res_out.frame_length;

endmodule

FILE: sv/sld_checker.sv
// Port-level checker for the deframer and its bind to the top level.
// Depends on sld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sld_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input sld_pkg::kind_t    kind,
    input logic [7:0]        payload_byte,
    input logic              last_byte,
    input logic              data_crc_ok,
    input logic [15:0]       frame_length
);
    import sld_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(kind) && $stable(payload_byte) && $stable(frame_length))

    `ASSERT_IMPLY(a_non_payload_clean, clk, rst_n, out_valid && kind != KIND_PAYLOAD,
        payload_byte == 8'd0 && !last_byte && !data_crc_ok)

    `ASSERT_IMPLY(a_crc_ok_on_last, clk, rst_n, out_valid && data_crc_ok,
        last_byte && kind == KIND_PAYLOAD)

    `ASSERT_IMPLY(a_sync_no_length, clk, rst_n, out_valid && kind == KIND_SYNC,
        frame_length == 16'd0)

endmodule

bind sync_length_crc16_deframer sld_checker u_sld_checker (.*);

FILE: bench/sync_length_crc16_deframer_tb.sv
`timescale 1ns / 1ps
// Testbench for sync_length_crc16_deframer: framed byte streams in, checked results out.
// Depends on sld_pkg and the deframer RTL; predicts each result in step with accepted bytes.
module sync_length_crc16_deframer_tb;
    import sld_pkg::*;

    localparam cfg_idx_t CFG_UNUSED = 2'd3;
    localparam int SKIP_PCT = 18;
    localparam int HOLD_CYCLES = 60;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_DCRC_HI,
        ST_DCRC_LO,
        ST_HCRC_HI,
        ST_HCRC_LO,
        ST_PAYLOAD
    } deframe_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    kind_t kind;
    logic [7:0] payload_byte;
    logic last_byte;
    logic data_crc_ok;
    logic [15:0] frame_length;
    logic cfg_write = 1'b0;
    cfg_idx_t cfg_index = CFG_SYNC_FIRST;
    logic [15:0] cfg_data = 16'h0000;

    logic no_gaps = 1'b0;
    logic hold_rx = 1'b0;
    int hold_cnt = 0;

    logic [7:0] rx_bytes_q[$];
    result_t frame_results_q[$];
    int unsigned pushed_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned err_cnt = 0;

    logic [7:0] cfg_sync_a = SYNC_FIRST_RST;
    logic [7:0] cfg_sync_b = SYNC_SECOND_RST;
    logic [15:0] cfg_max = MAX_LENGTH_RST;

    deframe_state_t st = ST_HUNT;
    logic [15:0] st_len = '0;
    logic [15:0] st_dcrc = '0;
    logic [7:0] st_hcrc_hi = '0;
    logic [15:0] st_crc = '0;
    logic [15:0] st_count = '0;

    sync_length_crc16_deframer u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .payload_byte(payload_byte),
        .last_byte(last_byte),
        .data_crc_ok(data_crc_ok),
        .frame_length(frame_length),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        result_t r;
        logic [15:0] hdr_rx;
        r = '0;
        accepted_cnt++;
        case (st)
            ST_SYNC2:
            begin
                if (b == cfg_sync_b)
                begin
                    st_crc = crc16_step(crc16_step(16'h0000, cfg_sync_a), cfg_sync_b);
                    st = ST_LEN_HI;
                    r.kind = KIND_SYNC;
                    frame_results_q.push_back(r);
                end
                else if (b != cfg_sync_a)
                    st = ST_HUNT;
            end
            ST_LEN_HI:
            begin
                st_len = {b, 8'h00};
                st_crc = crc16_step(st_crc, b);
                st = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                st_len[7:0] = b;
                st_crc = crc16_step(st_crc, b);
                st = ST_DCRC_HI;
            end
            ST_DCRC_HI:
            begin
                st_dcrc = {b, 8'h00};
                st_crc = crc16_step(st_crc, b);
                st = ST_DCRC_LO;
            end
            ST_DCRC_LO:
            begin
                st_dcrc[7:0] = b;
                st_crc = crc16_step(st_crc, b);
                st = ST_HCRC_HI;
            end
            ST_HCRC_HI:
            begin
                st_hcrc_hi = b;
                st = ST_HCRC_LO;
            end
            ST_HCRC_LO:
            begin
                hdr_rx = {st_hcrc_hi, b};
                r.frame_length = st_len;
                if (hdr_rx != st_crc)
                begin
                    st = ST_HUNT;
                    r.kind = KIND_HDR_CRC_ERR;
                    frame_results_q.push_back(r);
                end
                else if (st_len == 16'h0000 || st_len > cfg_max)
                begin
                    st = ST_HUNT;
                    r.kind = KIND_LEN_ERR;
                    frame_results_q.push_back(r);
                end
                else
                begin
                    st_crc = '0;
                    st_count = '0;
                    st = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                st_crc = crc16_step(st_crc, b);
                st_count = st_count + 16'd1;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.frame_length = st_len;
                if (st_count >= st_len)
                begin
                    st = ST_HUNT;
                    r.last_byte = 1'b1;
                    r.data_crc_ok = (st_crc == st_dcrc);
                end
                frame_results_q.push_back(r);
            end
            default:
            begin
                st = (b == cfg_sync_a) ? ST_SYNC2 : ST_HUNT;
            end
        endcase
    endtask

    function automatic int field_mismatch(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result();
        result_t want;
        if (frame_results_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual kind %0d byte %0h len %0h",
                     $time, kind, payload_byte, frame_length);
            err_cnt++;
        end
        else
        begin
            want = frame_results_q.pop_front();
            err_cnt += field_mismatch("kind", 16'(want.kind), 16'(kind));
            err_cnt += field_mismatch("payload_byte", 16'(want.payload_byte),
                                      16'(payload_byte));
            err_cnt += field_mismatch("last_byte", 16'(want.last_byte), 16'(last_byte));
            err_cnt += field_mismatch("data_crc_ok", 16'(want.data_crc_ok), 16'(data_crc_ok));
            err_cnt += field_mismatch("frame_length", want.frame_length, frame_length);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte);
            if (!in_valid || in_ready)
            begin
                if (rx_bytes_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= SKIP_PCT))
                begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_bytes_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (hold_rx && hold_cnt < HOLD_CYCLES)
            begin
                out_ready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
            end
            else
            begin
                out_ready <= no_gaps || ($urandom_range(0, 99) >= SKIP_PCT);
                if (!hold_rx)
                    hold_cnt <= 0;
            end
        end
    end

    task automatic push_rx(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        pushed_cnt++;
    endtask

    task automatic wait_drained();
        wait (accepted_cnt == pushed_cnt && frame_results_q.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST: cfg_sync_a = val[7:0];
            CFG_SYNC_SECOND: cfg_sync_b = val[7:0];
            CFG_MAX_LENGTH: cfg_max = val;
            default: ;
        endcase
    endtask

    task automatic queue_header(input logic [15:0] len, input logic [15:0] dcrc,
                                input logic [15:0] flip);
        logic [15:0] hcrc;
        hcrc = crc16_step(16'h0000, cfg_sync_a);
        hcrc = crc16_step(hcrc, cfg_sync_b);
        hcrc = crc16_step(hcrc, len[15:8]);
        hcrc = crc16_step(hcrc, len[7:0]);
        hcrc = crc16_step(hcrc, dcrc[15:8]);
        hcrc = crc16_step(hcrc, dcrc[7:0]);
        hcrc = hcrc ^ flip;
        push_rx(cfg_sync_a);
        push_rx(cfg_sync_b);
        push_rx(len[15:8]);
        push_rx(len[7:0]);
        push_rx(dcrc[15:8]);
        push_rx(dcrc[7:0]);
        push_rx(hcrc[15:8]);
        push_rx(hcrc[7:0]);
    endtask

    task automatic queue_frame(input logic [15:0] len, input logic hdr_bad,
                               input logic data_bad);
        logic [7:0] body[$];
        logic [15:0] dcrc;
        logic [15:0] flip;
        int n_lead;
        dcrc = '0;
        if (!hdr_bad && len != 16'h0000 && len <= cfg_max)
        begin
            for (int i = 0; i < len; i++)
            begin
                body.push_back(8'($urandom));
                dcrc = crc16_step(dcrc, body[i]);
            end
        end
        else
            dcrc = 16'($urandom);
        if (data_bad)
            dcrc = dcrc ^ (16'h0001 << $urandom_range(0, 15));
        flip = hdr_bad ? (16'h0001 << $urandom_range(0, 15)) : 16'h0000;
        n_lead = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n_lead) push_rx(cfg_sync_a);
        queue_header(len, dcrc, flip);
        foreach (body[i])
            push_rx(body[i]);
    endtask

    function automatic logic [15:0] good_len();
        int hi;
        hi = (cfg_max < 12) ? int'(cfg_max) : 12;
        if (cfg_max >= 40 && $urandom_range(0, 7) == 0)
            hi = 40;
        return 16'($urandom_range(1, hi));
    endfunction

    function automatic logic [15:0] bad_len();
        if (cfg_max == 16'hFFFF || $urandom_range(0, 3) == 0)
            return 16'h0000;
        return 16'($urandom_range(int'(cfg_max) + 1, 65535));
    endfunction

    task automatic random_traffic(input int n_items);
        int unsigned stop;
        int pick;
        stop = pushed_cnt + n_items;
        while (pushed_cnt < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                queue_frame(good_len(), 1'b0, $urandom_range(0, 9) == 0);
            else if (pick < 75)
                queue_frame(good_len(), 1'b1, 1'b0);
            else if (pick < 85)
                queue_frame(bad_len(), 1'b0, 1'b0);
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6)) push_rx(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) push_rx(cfg_sync_a);
                push_rx(8'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [15:0] pair_crc;
        int pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Repeated first sync byte, then a two-byte frame whose sender pauses mid-payload.
        pair_crc = crc16_step(crc16_step(16'h0000, 8'h00), 8'hFF);
        push_rx(cfg_sync_a);
        queue_header(16'd2, pair_crc, 16'h0000);
        push_rx(8'h00);
        wait_drained();
        push_rx(8'hFF);
        push_rx(cfg_sync_a);
        push_rx(8'h12);
        queue_header(16'h0000, 16'h5A5A, 16'h0000);
        queue_header(16'hFFFF, 16'hFFFF, 16'h8000);
        wait_drained();

        write_reg(CFG_SYNC_FIRST, {8'($urandom), 8'h00});
        write_reg(CFG_SYNC_SECOND, {8'($urandom), 8'hFF});
        write_reg(CFG_MAX_LENGTH, 16'h0001);
        write_reg(CFG_UNUSED, 16'($urandom));
        random_traffic(60);
        wait_drained();

        write_reg(CFG_MAX_LENGTH, 16'h0000);
        random_traffic(30);
        wait_drained();

        write_reg(CFG_SYNC_FIRST, 16'h007E);
        write_reg(CFG_SYNC_SECOND, 16'h007E);
        write_reg(CFG_MAX_LENGTH, 16'hFFFF);
        random_traffic(60);
        wait_drained();

        write_reg(CFG_SYNC_FIRST, 16'h00AA);
        write_reg(CFG_SYNC_SECOND, 16'h0055);
        write_reg(CFG_MAX_LENGTH, 16'hFFFE);
        random_traffic(40);
        wait_drained();

        @(posedge clk);
        no_gaps <= 1'b1;
        hold_rx <= 1'b1;
        queue_frame(16'd40, 1'b0, 1'b0);
        random_traffic(30);
        wait (hold_cnt == HOLD_CYCLES);
        @(posedge clk);
        hold_rx <= 1'b0;
        wait_drained();
        no_gaps <= 1'b0;

        repeat (4)
        begin
            write_reg(CFG_SYNC_FIRST, 16'($urandom));
            write_reg(CFG_SYNC_SECOND, 16'($urandom));
            pick = $urandom_range(0, 2);
            if (pick == 0)
                write_reg(CFG_MAX_LENGTH, 16'($urandom_range(1, 24)));
            else if (pick == 1)
                write_reg(CFG_MAX_LENGTH, 16'hFFFF);
            else
                write_reg(CFG_MAX_LENGTH, 16'($urandom_range(25, 65535)));
            random_traffic(50);
            wait_drained();
        end

        repeat (6) @(posedge clk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/sld_pkg.sv
sv/sld_cfg_regs.sv
sv/sld_in_reg.sv
sv/sld_frame_core.sv
sv/sld_out_reg.sv
sv/sync_length_crc16_deframer.sv
sv/sld_checker.sv
bench/sync_length_crc16_deframer_tb.sv
